/* design/svle_pkg.sv */
// Shared types, constants and the sine table function for the sine voice block.
package svle_pkg;

  // Default values for the top-level parameters
  localparam int PHASE_BITS_DEF     = 32;
  localparam int SINE_ADDR_BITS_DEF = 10;
  localparam int SAMPLE_BITS_DEF    = 24;

  // Fixed widths of the beat fields
  localparam int MIX_W  = 24;
  localparam int CNT_W  = 32;
  localparam int LEN_W  = 24;
  localparam int Q16_W  = 17;
  localparam int MAG_W  = 15;
  localparam int QUO_W  = 16;

  // Configuration port
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;
  localparam logic [2:0] REG_PHASE_INCREMENT = 3'd0;
  localparam logic [2:0] REG_ATTACK_SAMPLES  = 3'd1;
  localparam logic [2:0] REG_RELEASE_SAMPLES = 3'd2;
  localparam logic [2:0] REG_GAIN            = 3'd3;
  localparam logic [2:0] REG_PAN_LEFT        = 3'd4;
  localparam logic [2:0] REG_PAN_RIGHT       = 3'd5;

  localparam logic [31:0]      PHASE_INC_RST = 32'd0;
  localparam logic [LEN_W-1:0] ATTACK_RST    = 24'd960;
  localparam logic [LEN_W-1:0] RELEASE_RST   = 24'd48048;
  localparam logic [Q16_W-1:0] GAIN_RST      = 17'd65536;
  localparam logic [Q16_W-1:0] PAN_RST       = 17'd0;

  localparam logic [Q16_W-1:0] ENV_ONE = 17'd65536;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int LVL_W       = $clog2(QUEUE_DEPTH + 1);

  // Quotient bits per envelope divide, one per cycle
  localparam int DIV_STEPS = QUO_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  typedef enum logic [1:0] {
    ENV_ATTACK,
    ENV_HOLD,
    ENV_RELEASE,
    ENV_DONE
  } env_kind_t;

  typedef struct packed {
    logic [31:0]      phase_increment;
    logic [LEN_W-1:0] attack_samples;
    logic [LEN_W-1:0] release_samples;
    logic [Q16_W-1:0] gain;
    logic [Q16_W-1:0] pan_left;
    logic [Q16_W-1:0] pan_right;
  } cfg_t;

  // One classified sample waiting for the back end
  typedef struct packed {
    env_kind_t        kind;
    logic [LEN_W-1:0] num;
    logic [LEN_W-1:0] den;
    logic             neg;
    logic [MIX_W-1:0] mix_left;
    logic [MIX_W-1:0] mix_right;
    logic             done;
  } job_t;

  typedef struct packed {
    logic             full;
    logic             empty;
    logic [LVL_W-1:0] level;
  } q_status_t;

  localparam logic [63:0] Q30_ONE     = 64'd1073741824;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // 32767*sin(j/2^addr_bits * pi/2), Q30 Taylor series, rounded; elaboration only
  function automatic logic [MAG_W-1:0] sine_entry(input logic [63:0] j,
                                                  input int unsigned addr_bits);
    logic [63:0] t;
    logic [63:0] t2;
    logic [63:0] r;
    logic [63:0] s;
    logic [63:0] v;
    t  = (j * HALF_PI_Q30) >> addr_bits;
    t2 = (t * t) >> 30;
    r  = Q30_ONE;
    r  = Q30_ONE - ((t2 * r) >> 30) / 64'd110;
    r  = Q30_ONE - ((t2 * r) >> 30) / 64'd72;
    r  = Q30_ONE - ((t2 * r) >> 30) / 64'd42;
    r  = Q30_ONE - ((t2 * r) >> 30) / 64'd20;
    r  = Q30_ONE - ((t2 * r) >> 30) / 64'd6;
    s  = (t * r) >> 30;
    v  = (s * 64'd32767 + (Q30_ONE >> 1)) >> 30;
    return v[MAG_W-1:0];
  endfunction

endpackage

/* design/svle_front.sv */
// Front end: takes input beats, updates voice state and classifies the envelope.
module svle_front import svle_pkg::*; #(
  parameter int PHASE_BITS     = PHASE_BITS_DEF,
  parameter int SINE_ADDR_BITS = SINE_ADDR_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    item_valid,
  output logic                    item_ready,
  input  logic                    note_on,
  input  logic                    note_off,
  input  logic [MIX_W-1:0]        mix_in_left,
  input  logic [MIX_W-1:0]        mix_in_right,
  input  cfg_t                    cfg,
  input  logic                    q_full,
  output logic                    push,
  output job_t                    push_job,
  output logic [SINE_ADDR_BITS:0] push_idx
);

  localparam int INC_W = (PHASE_BITS < 32) ? PHASE_BITS : 32;
  localparam int K_LSB = PHASE_BITS - 2 - SINE_ADDR_BITS;
  localparam logic [SINE_ADDR_BITS:0] QUARTER = {1'b1, {SINE_ADDR_BITS{1'b0}}};

  logic [PHASE_BITS-1:0]     phase_acc, phase_next, phase_cur, phase_inc;
  logic [CNT_W-1:0]          sample_count, count_next, count_cur;
  logic [CNT_W-1:0]          release_start, release_next, delta;
  logic                      released, released_next;
  logic                      done_flag, done_next;
  logic [1:0]                quad;
  logic [SINE_ADDR_BITS-1:0] k;

  assign item_ready = !q_full;
  assign push       = item_valid && !q_full;
  assign phase_inc  = PHASE_BITS'(cfg.phase_increment[INC_W-1:0]);

  always_comb begin
    // note on restarts the voice before anything else
    phase_cur     = note_on ? '0 : phase_acc;
    count_cur     = note_on ? '0 : sample_count;
    release_next  = note_on ? '0 : release_start;
    released_next = note_on ? 1'b0 : released;
    done_next     = note_on ? 1'b0 : done_flag;
    if (note_off && !released_next) begin
      release_next  = count_cur;
      released_next = 1'b1;
    end
    delta = count_cur - release_next;

    push_job.kind = ENV_HOLD;
    push_job.num  = '0;
    push_job.den  = '0;
    if (count_cur < {8'd0, cfg.attack_samples}) begin
      push_job.kind = ENV_ATTACK;
      push_job.num  = count_cur[LEN_W-1:0];
      push_job.den  = cfg.attack_samples;
    end else if (!released_next || count_cur < release_next) begin
      push_job.kind = ENV_HOLD;
    end else if (delta < {8'd0, cfg.release_samples}) begin
      push_job.kind = ENV_RELEASE;
      push_job.num  = delta[LEN_W-1:0];
      push_job.den  = cfg.release_samples;
    end else begin
      push_job.kind = ENV_DONE;
      done_next     = 1'b1;
    end
    push_job.done      = done_next;
    push_job.mix_left  = mix_in_left;
    push_job.mix_right = mix_in_right;

    // quarter-wave addressing: odd quadrants run the table backwards
    quad          = phase_cur[PHASE_BITS-1 -: 2];
    k             = phase_cur[K_LSB +: SINE_ADDR_BITS];
    push_idx      = quad[0] ? (QUARTER - {1'b0, k}) : {1'b0, k};
    push_job.neg  = quad[1];

    phase_next = phase_cur + phase_inc;
    count_next = (count_cur == '1) ? count_cur : count_cur + 32'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_acc     <= '0;
      sample_count  <= '0;
      release_start <= '0;
      released      <= 1'b0;
      done_flag     <= 1'b0;
    end else if (push) begin
      phase_acc     <= phase_next;
      sample_count  <= count_next;
      release_start <= release_next;
      released      <= released_next;
      done_flag     <= done_next;
    end
  end

endmodule

/* design/svle_queue.sv */
// Short FIFO of classified samples between front and back.
module svle_queue import svle_pkg::*; #(
  parameter int IDX_W = SINE_ADDR_BITS_DEF + 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  job_t             push_job,
  input  logic [IDX_W-1:0] push_idx,
  input  logic             pop,
  output job_t             pop_job,
  output logic [IDX_W-1:0] pop_idx,
  output q_status_t        status
);

  job_t             jobs [QUEUE_DEPTH];
  logic [IDX_W-1:0] idxs [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [LVL_W-1:0] level;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign pop_job      = jobs[rd_ptr];
  assign pop_idx      = idxs[rd_ptr];
  assign status.level = level;
  assign status.full  = (level == LVL_W'(QUEUE_DEPTH));
  assign status.empty = (level == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      jobs[wr_ptr] <= push_job;
      idxs[wr_ptr] <= push_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) wr_ptr <= ptr_inc(wr_ptr);
      if (pop)  rd_ptr <= ptr_inc(rd_ptr);
      if (push && !pop) begin
        level <= level + LVL_W'(1);
      end else if (pop && !push) begin
        level <= level - LVL_W'(1);
      end
    end
  end

endmodule

/* design/svle_back.sv */
// Back end: sine lookup, serial envelope divide, shared multiplier, mix and saturate.
module svle_back import svle_pkg::*; #(
  parameter int SINE_ADDR_BITS = SINE_ADDR_BITS_DEF,
  parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  cfg_t                    cfg,
  input  logic                    q_empty,
  output logic                    pop,
  input  job_t                    pop_job,
  input  logic [SINE_ADDR_BITS:0] pop_idx,
  output logic                    busy,
  output logic                    result_valid,
  input  logic                    result_ready,
  output logic [MIX_W-1:0]        mix_out_left,
  output logic [MIX_W-1:0]        mix_out_right,
  output logic                    voice_done
);

  localparam int ROM_N  = (1 << SINE_ADDR_BITS) + 1;
  localparam int PROD_W = 2 * Q16_W;
  localparam int SH     = SAMPLE_BITS - 16;
  localparam int SUM_W  = (SAMPLE_BITS + 4 > MIX_W + 2) ? SAMPLE_BITS + 4 : MIX_W + 2;
  localparam logic signed [SUM_W-1:0] SAT_HI =
    SUM_W'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
  localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);

  typedef enum logic [2:0] {
    S_IDLE, S_DIV, S_ENV, S_MUL1, S_MUL2, S_MUL3, S_MUL4, S_SUM
  } state_t;

  state_t            state;
  job_t              job;
  logic [MAG_W-1:0]  sine_rom [ROM_N];
  logic [MAG_W-1:0]  rom_q;
  logic [LEN_W-1:0]  rem;
  logic [LEN_W:0]    rem_dbl;
  logic [QUO_W-1:0]  quo;
  logic [STEP_W-1:0] step;
  logic [Q16_W-1:0]  env, m2, c_left, rnd;
  logic [Q16_W-1:0]  mul_a, mul_b;
  logic [PROD_W-1:0] prod;

  for (genvar j = 0; j < ROM_N; j++) begin : g_rom
    localparam logic [MAG_W-1:0] ENTRY = sine_entry(64'(j), SINE_ADDR_BITS);
    assign sine_rom[j] = ENTRY;
  end

  function automatic logic [MIX_W-1:0] mix_sat(input logic signed [MIX_W-1:0] base,
                                                input logic [Q16_W-1:0] c,
                                                input logic neg);
    logic signed [SUM_W-1:0] b_ext;
    logic signed [SUM_W-1:0] c_ext;
    logic signed [SUM_W-1:0] v;
    b_ext = SUM_W'(base);
    c_ext = $signed(SUM_W'(c) << SH);
    v     = neg ? b_ext - c_ext : b_ext + c_ext;
    if (v > SAT_HI) v = SAT_HI;
    if (v < SAT_LO) v = SAT_LO;
    return v[MIX_W-1:0];
  endfunction

  assign pop     = (state == S_IDLE) && !q_empty;
  assign busy    = (state != S_IDLE);
  assign rem_dbl = {rem, 1'b0};
  // round half up on the Q18.16 product
  assign rnd     = Q16_W'((prod + PROD_W'(32768)) >> 16);

  always_comb begin
    case (state)
      S_MUL1: begin
        mul_a = {2'b00, rom_q};
        mul_b = env;
      end
      S_MUL2: begin
        mul_a = rnd;
        mul_b = cfg.gain;
      end
      S_MUL3: begin
        mul_a = rnd;
        mul_b = cfg.pan_left;
      end
      default: begin
        mul_a = m2;
        mul_b = cfg.pan_right;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      // S_SUM owns result_valid while it hands over a new beat
      if (result_valid && result_ready && state != S_SUM) result_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (!q_empty) begin
            job   <= pop_job;
            rom_q <= sine_rom[pop_idx];
            rem   <= pop_job.num;
            quo   <= '0;
            step  <= '0;
            if (pop_job.kind == ENV_ATTACK || pop_job.kind == ENV_RELEASE) begin
              state <= S_DIV;
            end else begin
              state <= S_ENV;
            end
          end
        end
        S_DIV: begin
          // restoring divide, one quotient bit per cycle
          if (rem_dbl >= {1'b0, job.den}) begin
            rem <= LEN_W'(rem_dbl - {1'b0, job.den});
            quo <= {quo[QUO_W-2:0], 1'b1};
          end else begin
            rem <= rem_dbl[LEN_W-1:0];
            quo <= {quo[QUO_W-2:0], 1'b0};
          end
          step <= step + STEP_W'(1);
          if (step == STEP_W'(DIV_STEPS - 1)) state <= S_ENV;
        end
        S_ENV: begin
          case (job.kind)
            ENV_ATTACK:  env <= {1'b0, quo};
            ENV_RELEASE: env <= ENV_ONE - {1'b0, quo};
            ENV_HOLD:    env <= ENV_ONE;
            default:     env <= '0;
          endcase
          state <= S_MUL1;
        end
        S_MUL1: begin
          prod  <= mul_a * mul_b;
          state <= S_MUL2;
        end
        S_MUL2: begin
          prod  <= mul_a * mul_b;
          state <= S_MUL3;
        end
        S_MUL3: begin
          m2    <= rnd;
          prod  <= mul_a * mul_b;
          state <= S_MUL4;
        end
        S_MUL4: begin
          c_left <= rnd;
          prod   <= mul_a * mul_b;
          state  <= S_SUM;
        end
        S_SUM: begin
          if (!result_valid || result_ready) begin
            mix_out_left  <= mix_sat($signed(job.mix_left), c_left, job.neg);
            mix_out_right <= mix_sat($signed(job.mix_right), rnd, job.neg);
            voice_done    <= job.done;
            result_valid  <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* design/sine_voice_linear_ar_envelope.sv */
// Top level of one sine synth voice with a linear attack/release envelope.
//
// One input beat is one audio sample: note_on/note_off flags plus the stereo mix
// built so far; one result beat returns that mix with this voice added and
// saturated, plus the sticky voice_done flag. The front end takes a beat, advances
// phase and sample counter, latches the release point and classifies the
// envelope segment (attack, hold, release, done); it then drops the sample into
// a two-entry queue. The back end works one sample at a time: a registered
// quarter-wave sine lookup, a restoring divider that makes one quotient bit per
// cycle for the envelope ramps, and one shared 17x17 multiplier used four times
// (envelope, gain, left pan, right pan). Only a sample on an attack or release
// ramp passes through the divider; a held or finished sample goes straight to
// the envelope step. The queue lets the front accept up to two more beats while
// the back end is busy or a result waits on result_ready. Registers sit on an
// APB-style port at byte addresses 4*i:
// phase_increment, attack_samples, release_samples, gain, pan_left, pan_right;
// write them only while the voice is idle. pready is tied high.
module sine_voice_linear_ar_envelope import svle_pkg::*; #(
  parameter int PHASE_BITS     = PHASE_BITS_DEF,
  parameter int SINE_ADDR_BITS = SINE_ADDR_BITS_DEF,
  parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  // input beats
  input  logic                  item_valid,
  output logic                  item_ready,
  input  logic                  note_on,
  input  logic                  note_off,
  input  logic [MIX_W-1:0]      mix_in_left,
  input  logic [MIX_W-1:0]      mix_in_right,
  // result beats
  output logic                  result_valid,
  input  logic                  result_ready,
  output logic [MIX_W-1:0]      mix_out_left,
  output logic [MIX_W-1:0]      mix_out_right,
  output logic                  voice_done
);

  localparam int IDX_W = SINE_ADDR_BITS + 1;

  cfg_t             cfg;
  logic             cfg_wr;
  logic [2:0]       reg_sel;
  logic             push, pop, back_busy;
  job_t             push_job, pop_job;
  logic [IDX_W-1:0] push_idx, pop_idx;
  q_status_t        q_stat;

  // ---------------- configuration registers ----------------
  assign pready  = 1'b1;
  assign reg_sel = paddr[CFG_ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.phase_increment <= PHASE_INC_RST;
      cfg.attack_samples  <= ATTACK_RST;
      cfg.release_samples <= RELEASE_RST;
      cfg.gain            <= GAIN_RST;
      cfg.pan_left        <= PAN_RST;
      cfg.pan_right       <= PAN_RST;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_PHASE_INCREMENT: cfg.phase_increment <= pwdata;
        REG_ATTACK_SAMPLES:  cfg.attack_samples  <= pwdata[LEN_W-1:0];
        REG_RELEASE_SAMPLES: cfg.release_samples <= pwdata[LEN_W-1:0];
        REG_GAIN:            cfg.gain            <= pwdata[Q16_W-1:0];
        REG_PAN_LEFT:        cfg.pan_left        <= pwdata[Q16_W-1:0];
        REG_PAN_RIGHT:       cfg.pan_right       <= pwdata[Q16_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_PHASE_INCREMENT: prdata = cfg.phase_increment;
      REG_ATTACK_SAMPLES:  prdata = CFG_DATA_W'(cfg.attack_samples);
      REG_RELEASE_SAMPLES: prdata = CFG_DATA_W'(cfg.release_samples);
      REG_GAIN:            prdata = CFG_DATA_W'(cfg.gain);
      REG_PAN_LEFT:        prdata = CFG_DATA_W'(cfg.pan_left);
      REG_PAN_RIGHT:       prdata = CFG_DATA_W'(cfg.pan_right);
      default:             prdata = '0;
    endcase
  end

  // ---------------- front: voice state and envelope segment ----------------
  svle_front #(
    .PHASE_BITS    (PHASE_BITS),
    .SINE_ADDR_BITS(SINE_ADDR_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .note_on     (note_on),
    .note_off    (note_off),
    .mix_in_left (mix_in_left),
    .mix_in_right(mix_in_right),
    .cfg         (cfg),
    .q_full      (q_stat.full),
    .push        (push),
    .push_job    (push_job),
    .push_idx    (push_idx)
  );

  // ---------------- queue between front and back ----------------
  svle_queue #(
    .IDX_W(IDX_W)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_job(push_job),
    .push_idx(push_idx),
    .pop     (pop),
    .pop_job (pop_job),
    .pop_idx (pop_idx),
    .status  (q_stat)
  );

  // ---------------- back: sine, envelope divide, scaling, mix ----------------
  svle_back #(
    .SINE_ADDR_BITS(SINE_ADDR_BITS),
    .SAMPLE_BITS   (SAMPLE_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_empty      (q_stat.empty),
    .pop          (pop),
    .pop_job      (pop_job),
    .pop_idx      (pop_idx),
    .busy         (back_busy),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .mix_out_left (mix_out_left),
    .mix_out_right(mix_out_right),
    .voice_done   (voice_done)
  );

  // ---------------- assertions ----------------
  a_q_level: assert property (@(posedge clk) disable iff (rst)
    q_stat.level <= LVL_W'(QUEUE_DEPTH))
    else $error("queue level above depth");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_stat.full)
    else $error("sample pushed into full queue");

  a_pop_data: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_stat.empty)
    else $error("sample popped from empty queue");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    (!back_busy && q_stat.empty && !push) |=> !$rose(result_valid))
    else $error("result beat with no sample in flight");

endmodule
